[design/leapfrog_verlet_integrator_unit_macros.svh]
// assertion macros shared by the integrator modules
// no dependencies; included by files that carry concurrent checks
`ifndef LEAPFROG_VERLET_INTEGRATOR_UNIT_MACROS_SVH
`define LEAPFROG_VERLET_INTEGRATOR_UNIT_MACROS_SVH

// same-cycle implication
`define LVI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integrator check failed");

// next-cycle implication
`define LVI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integrator check failed");

`endif

[design/lvi_pkg.sv]
// shared types, constants and saturation helpers for the leapfrog integrator
// no dependencies
`default_nettype none

package lvi_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int WORD_W            = 32;
    localparam int WIDE_W            = 35;
    localparam int DT_W              = 16;
    localparam int PIDX_W            = 10;
    localparam int PROD_W            = 49;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_KICK  = 2'd1,
        OP_DRIFT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        AX_X    = 2'd0,
        AX_Y    = 2'd1,
        AX_Z    = 2'd2,
        AX_NONE = 2'd3
    } t_axis;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic mul;
        logic calc;
    } t_cmd;

    function automatic t_wide ext(input t_word x);
        ext = {{(WIDE_W-WORD_W){x[WORD_W-1]}}, x};
    endfunction

    function automatic logic sat_hit(input t_wide x);
        logic [WIDE_W-WORD_W:0] top;
        top     = x[WIDE_W-1:WORD_W-1];
        sat_hit = !((&top) || !(|top));
    endfunction

    function automatic t_word sat_word(input t_wide x);
        if (sat_hit(x)) begin
            sat_word = x[WIDE_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            sat_word = x[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[design/lvi_ram.sv]
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none

module lvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3072
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/lvi_ctrl.sv]
// sequencer for the integrator: read, multiply, update, strobe
// depends on lvi_pkg and the assertion macro header
`default_nettype none
`include "leapfrog_verlet_integrator_unit_macros.svh"

module lvi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_done,
    output lvi_pkg::t_cmd      o_cmd
);
    import lvi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CALC;
            ST_CALC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        n_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_READ: o_cmd.rd = 1'b1;
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_done     = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_done = r_done;

    `LVI_ASSERT_NEXT(a_start_reads, i_clk, i_rst_n, start && !busy, r_state == ST_READ)
    `LVI_ASSERT_NEXT(a_calc_strobes, i_clk, i_rst_n, r_state == ST_CALC, o_done && !busy)
    `LVI_ASSERT_SAME(a_strobe_after_calc, i_clk, i_rst_n, o_done, $past(r_state) == ST_CALC)

endmodule

`default_nettype wire

[design/lvi_dp.sv]
// integrator datapath: capture, state memories, shared multiplier, saturating sums
// depends on lvi_pkg, lvi_ram and the assertion macro header
`default_nettype none
`include "leapfrog_verlet_integrator_unit_macros.svh"

module lvi_dp #(
    parameter int MAX_PARTICLES = lvi_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lvi_pkg::t_cmd               i_cmd,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [lvi_pkg::PIDX_W-1:0]  i_particle_index,
    input  wire logic [1:0]                  i_axis,
    input  wire lvi_pkg::t_word              i_acceleration,
    input  wire lvi_pkg::t_word              i_velocity_in,
    input  wire lvi_pkg::t_word              i_position_in,
    input  wire lvi_pkg::t_word              i_solvent_center_in,
    input  wire logic                        i_write_back_velocity,
    input  wire logic [lvi_pkg::DT_W-1:0]    i_time_step,
    input  wire logic                        i_solvent_center_on,
    output lvi_pkg::t_word                   o_velocity_out,
    output logic                             o_velocity_update,
    output lvi_pkg::t_word                   o_position_out,
    output lvi_pkg::t_word                   o_solvent_center_out,
    output logic                             o_saturated
);
    import lvi_pkg::*;

    localparam int SLOTS  = 3 * MAX_PARTICLES;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CALC_W = (SLOT_W > PIDX_W + 2) ? SLOT_W : PIDX_W + 2;
    localparam int CMP_W  = 17;
    localparam logic [CMP_W-1:0] MAXP = CMP_W'(MAX_PARTICLES);

    t_op                      r_op;
    logic [SLOT_W-1:0]        r_slot;
    t_word                    r_acc;
    t_word                    r_vin;
    t_word                    r_pos;
    t_word                    r_sc;
    logic                     r_wb;
    logic signed [PROD_W-1:0] r_prod;

    t_word                    r_vout;
    logic                     r_upd;
    t_word                    r_pos_out;
    t_word                    r_sc_out;
    logic                     r_sat;

    logic                     in_ok;
    logic [CALC_W-1:0]        slot_full;
    t_word                    vm_rd;
    t_word                    vp_rd;
    t_word                    mul_a;
    t_word                    p16;
    t_word                    p17;

    t_wide                    s_a;
    t_wide                    s_b;
    t_wide                    s_vp;
    t_word                    vp_k;
    t_wide                    s_mid;
    t_wide                    s_pos;
    t_wide                    s_sc;
    t_wide                    s_g;
    t_wide                    g_half;

    logic                     we_vm;
    logic                     we_vp;
    t_word                    vm_wd;
    t_word                    vp_wd;
    t_word                    n_vout;
    logic                     n_upd;
    t_word                    n_pos_out;
    t_word                    n_sc_out;
    logic                     n_sat;

    assign in_ok = (t_op'(i_operation) != OP_NONE) && (t_axis'(i_axis) != AX_NONE)
                   && (CMP_W'(i_particle_index) < MAXP);
    assign slot_full = (CALC_W'(i_particle_index) << 1) + CALC_W'(i_particle_index)
                       + CALC_W'(i_axis);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= in_ok ? t_op'(i_operation) : OP_NONE;
            r_slot <= in_ok ? slot_full[SLOT_W-1:0] : '0;
            r_acc  <= i_acceleration;
            r_vin  <= i_velocity_in;
            r_pos  <= i_position_in;
            r_sc   <= i_solvent_center_in;
            r_wb   <= i_write_back_velocity;
        end
    end

    lvi_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_vm_ram (
        .i_clk   (i_clk),
        .i_we    (we_vm),
        .i_re    (i_cmd.rd),
        .i_addr  (r_slot),
        .i_wdata (vm_wd),
        .o_rdata (vm_rd)
    );

    lvi_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_vp_ram (
        .i_clk   (i_clk),
        .i_we    (we_vp),
        .i_re    (i_cmd.rd),
        .i_addr  (r_slot),
        .i_wdata (vp_wd),
        .o_rdata (vp_rd)
    );

    // one multiplier: step times acceleration, or times v_plus on drift
    assign mul_a = (r_op == OP_DRIFT) ? vp_rd : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(mul_a) * $signed({1'b0, i_time_step});
        end
    end

    assign p16 = r_prod[WORD_W+15:16];
    assign p17 = r_prod[WORD_W+16:17];

    assign s_a    = ext(r_vin) - ext(p17);
    assign s_b    = ext(r_vin) + ext(p17);
    assign s_vp   = ext(vm_rd) + ext(p16);
    assign vp_k   = sat_word(s_vp);
    assign s_mid  = ext(vm_rd) + ext(vp_k);
    assign s_pos  = ext(r_pos) + ext(p16);
    assign s_sc   = ext(r_sc) + ext(p16);
    assign s_g    = (ext(vp_rd) <<< 1) + ext(vp_rd) - ext(vm_rd);
    assign g_half = s_g >>> 1;

    always_comb begin
        we_vm     = 1'b0;
        we_vp     = 1'b0;
        vm_wd     = vp_rd;
        vp_wd     = vp_k;
        n_vout    = r_vin;
        n_upd     = 1'b0;
        n_pos_out = r_pos;
        n_sc_out  = r_sc;
        n_sat     = 1'b0;
        unique case (r_op)
            OP_INIT: begin
                we_vm = i_cmd.calc;
                we_vp = i_cmd.calc;
                vm_wd = sat_word(s_a);
                vp_wd = sat_word(s_b);
                n_sat = sat_hit(s_a) || sat_hit(s_b);
            end
            OP_KICK: begin
                we_vp  = i_cmd.calc;
                n_vout = s_mid[WORD_W:1];
                n_upd  = r_wb;
                n_sat  = sat_hit(s_vp);
            end
            OP_DRIFT: begin
                we_vm     = i_cmd.calc;
                n_vout    = sat_word(g_half);
                n_upd     = 1'b1;
                n_pos_out = sat_word(s_pos);
                n_sat     = sat_hit(s_pos) || sat_hit(g_half);
                if (i_solvent_center_on) begin
                    n_sc_out = sat_word(s_sc);
                    n_sat    = sat_hit(s_pos) || sat_hit(g_half) || sat_hit(s_sc);
                end
            end
            default: n_upd = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_vout    <= n_vout;
            r_upd     <= n_upd;
            r_pos_out <= n_pos_out;
            r_sc_out  <= n_sc_out;
            r_sat     <= n_sat;
        end
    end

    assign o_velocity_out       = r_vout;
    assign o_velocity_update    = r_upd;
    assign o_position_out       = r_pos_out;
    assign o_solvent_center_out = r_sc_out;
    assign o_saturated          = r_sat;

    `LVI_ASSERT_SAME(a_write_in_calc, i_clk, i_rst_n, we_vm || we_vp, i_cmd.calc)
    `LVI_ASSERT_SAME(a_no_write_pass, i_clk, i_rst_n, we_vm || we_vp, r_op != OP_NONE)
    `LVI_ASSERT_SAME(a_one_cmd, i_clk, i_rst_n, 1'b1,
                     $onehot0({i_cmd.load, i_cmd.rd, i_cmd.mul, i_cmd.calc}))

endmodule

`default_nettype wire

[design/leapfrog_verlet_integrator_unit.sv]
// leapfrog verlet integrator, top level: register port, sequencer and datapath
// depends on lvi_pkg, lvi_ctrl, lvi_dp (which holds lvi_ram)
//
// channel   | handshake              | beat
// ----------+------------------------+---------------------------------------------
// item in   | start high, busy low   | operation, index, axis, acc, vel, pos, centre
// result    | o_done strobe, 1 cycle | velocity, update flag, pos, centre, saturated
// registers | psel/penable/pwrite    | time step at 0x0, solvent mode at 0x4
//
// an item goes through memory read, multiply, update and the result strobe
// the next item is taken in the cycle the strobe is high; none is taken while busy
// each state memory is read once per item, written at most once, through one port
// synchronous active-low reset clears sequencer and solvent mode, time step to 655
// the receiver cannot stall; o_done lasts one cycle, results hold to the next update
`default_nettype none

module leapfrog_verlet_integrator_unit #(
    parameter int MAX_PARTICLES = lvi_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [lvi_pkg::PIDX_W-1:0]  i_particle_index,
    input  wire logic [1:0]                  i_axis,
    input  wire lvi_pkg::t_word              i_acceleration,
    input  wire lvi_pkg::t_word              i_velocity_in,
    input  wire lvi_pkg::t_word              i_position_in,
    input  wire lvi_pkg::t_word              i_solvent_center_in,
    input  wire logic                        i_write_back_velocity,
    output logic                             o_done,
    output lvi_pkg::t_word                   o_velocity_out,
    output logic                             o_velocity_update,
    output lvi_pkg::t_word                   o_position_out,
    output lvi_pkg::t_word                   o_solvent_center_out,
    output logic                             o_saturated,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import lvi_pkg::*;

    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_SOLVENT   = 1'b1;
    localparam logic [DT_W-1:0] TIME_STEP_RST = DT_W'(655);

    logic [DT_W-1:0] r_time_step;
    logic            r_solvent_on;
    logic            wr_en;
    t_cmd            cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= TIME_STEP_RST;
            r_solvent_on <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TIME_STEP: r_time_step  <= pwdata[DT_W-1:0];
                REG_SOLVENT:   r_solvent_on <= pwdata[0];
                default:       r_solvent_on <= r_solvent_on;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIME_STEP: prdata = {{(32-DT_W){1'b0}}, r_time_step};
            REG_SOLVENT:   prdata = {31'b0, r_solvent_on};
            default:       prdata = '0;
        endcase
    end

    lvi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    lvi_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_operation           (i_operation),
        .i_particle_index      (i_particle_index),
        .i_axis                (i_axis),
        .i_acceleration        (i_acceleration),
        .i_velocity_in         (i_velocity_in),
        .i_position_in         (i_position_in),
        .i_solvent_center_in   (i_solvent_center_in),
        .i_write_back_velocity (i_write_back_velocity),
        .i_time_step           (r_time_step),
        .i_solvent_center_on   (r_solvent_on),
        .o_velocity_out        (o_velocity_out),
        .o_velocity_update     (o_velocity_update),
        .o_position_out        (o_position_out),
        .o_solvent_center_out  (o_solvent_center_out),
        .o_saturated           (o_saturated)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// testbench for leapfrog_verlet_integrator_unit: directed table then random beats,
// every result checked field by field against its listed value or an in-bench fixed-point predictor
// depends on lvi_pkg and the integrator rtl
`timescale 1ns / 1ps

module tb_top;
    import lvi_pkg::*;

    localparam logic [2:0] REG_TIME_STEP    = 3'h0;
    localparam logic [2:0] REG_SOLVENT_MODE = 3'h4;
    localparam int         SLOT_COUNT       = 3 * MAX_PARTICLES_DEF;
    localparam int         DIRECTED_COUNT   = 17;
    localparam int         CYCLE_LIMIT      = 100000;
    localparam longint     WORD_MAX         = 2147483647;
    localparam longint     WORD_MIN         = -longint'(2147483647) - 1;
    localparam t_word      MAXW             = 32'sh7fff_ffff;
    localparam t_word      MINW             = 32'sh8000_0000;

    typedef struct packed {
        t_op                op;
        logic [PIDX_W-1:0]  pidx;
        t_axis              axis;
        t_word              acc;
        t_word              vel;
        t_word              pos;
        t_word              ctr;
        logic               wb;
    } t_beat_in;

    typedef struct packed {
        t_word vel;
        logic  upd;
        t_word pos;
        t_word ctr;
        logic  sat;
    } t_beat_out;

    typedef struct packed {
        t_beat_in  stim;
        logic      typed;
        t_beat_out want;
    } t_dir_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_beat_in    drive_beat = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    logic        busy;
    logic        o_done;
    t_word       o_velocity_out;
    logic        o_velocity_update;
    t_word       o_position_out;
    t_word       o_solvent_center_out;
    logic        o_saturated;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register mirror
    logic [DT_W-1:0] step_q016   = 16'd655;
    logic            centre_mode = 1'b0;
    t_word           vminus_mem [SLOT_COUNT];
    t_word           vplus_mem  [SLOT_COUNT];
    bit              slot_live  [SLOT_COUNT];

    t_beat_out expected_results [$];
    t_beat_out oldest_result;
    t_dir_row  directed_rows [DIRECTED_COUNT];
    int        fail_count   = 0;
    bit        calm_stretch = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    leapfrog_verlet_integrator_unit i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_operation           (drive_beat.op),
        .i_particle_index      (drive_beat.pidx),
        .i_axis                (drive_beat.axis),
        .i_acceleration        (drive_beat.acc),
        .i_velocity_in         (drive_beat.vel),
        .i_position_in         (drive_beat.pos),
        .i_solvent_center_in   (drive_beat.ctr),
        .i_write_back_velocity (drive_beat.wb),
        .o_done                (o_done),
        .o_velocity_out        (o_velocity_out),
        .o_velocity_update     (o_velocity_update),
        .o_position_out        (o_position_out),
        .o_solvent_center_out  (o_solvent_center_out),
        .o_saturated           (o_saturated),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    function automatic bit clips(input longint x);
        return (x > WORD_MAX) || (x < WORD_MIN);
    endfunction

    function automatic t_word clamp_word(input longint x);
        if (x > WORD_MAX) return MAXW;
        if (x < WORD_MIN) return MINW;
        return t_word'(x);
    endfunction

    function automatic t_beat_out integrate_beat(input t_beat_in b);
        t_beat_out r;
        longint    dt;
        longint    vm;
        longint    vp;
        longint    sum;
        longint    dr;
        int        slot;
        r    = '{vel: b.vel, upd: 1'b0, pos: b.pos, ctr: b.ctr, sat: 1'b0};
        dt   = longint'(step_q016);
        slot = int'(b.pidx) * 3 + int'(b.axis);
        if (b.op == OP_NONE || b.axis == AX_NONE) return r;
        case (b.op)
            OP_INIT: begin
                dr  = (longint'(b.acc) * dt) >>> 17;
                sum = longint'(b.vel) - dr;
                r.sat |= clips(sum);
                vminus_mem[slot] = clamp_word(sum);
                sum = longint'(b.vel) + dr;
                r.sat |= clips(sum);
                vplus_mem[slot] = clamp_word(sum);
                slot_live[slot] = 1'b1;
            end
            OP_KICK: begin
                vm  = longint'(vminus_mem[slot]);
                sum = vm + ((longint'(b.acc) * dt) >>> 16);
                r.sat = clips(sum);
                vp  = longint'(clamp_word(sum));
                vplus_mem[slot] = clamp_word(sum);
                r.vel = t_word'((vm + vp) >>> 1);
                r.upd = b.wb;
            end
            default: begin
                vm  = longint'(vminus_mem[slot]);
                vp  = longint'(vplus_mem[slot]);
                dr  = (vp * dt) >>> 16;
                sum = longint'(b.pos) + dr;
                r.sat |= clips(sum);
                r.pos = clamp_word(sum);
                if (centre_mode) begin
                    sum = longint'(b.ctr) + dr;
                    r.sat |= clips(sum);
                    r.ctr = clamp_word(sum);
                end
                sum = (3 * vp - vm) >>> 1;
                r.sat |= clips(sum);
                r.vel = clamp_word(sum);
                vminus_mem[slot] = vplus_mem[slot];
                r.upd = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic t_word random_word();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return MAXW;
                    1: return MINW;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return t_word'($urandom);
            4: begin
                if ($urandom_range(1)) return t_word'(32'h7fff_ffff - $urandom_range(1 << 20));
                return t_word'(32'h8000_0000 + $urandom_range(1 << 20));
            end
            default: return t_word'($urandom_range(32'h0020_0000)) - t_word'(32'h0010_0000);
        endcase
    endfunction

    // mostly init/kick/drift runs on a small particle pool; kick and drift only on live slots
    function automatic t_beat_in random_beat();
        t_beat_in b;
        int       pick;
        int       slot;
        if ($urandom_range(99) < 70) b.pidx = PIDX_W'($urandom_range(15));
        else b.pidx = PIDX_W'($urandom);
        b.axis = ($urandom_range(99) < 4) ? AX_NONE : t_axis'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 4) b.op = OP_NONE;
        else if (pick < 20) b.op = OP_INIT;
        else if (pick < 60) b.op = OP_KICK;
        else b.op = OP_DRIFT;
        slot = int'(b.pidx) * 3 + int'(b.axis);
        if ((b.op == OP_KICK || b.op == OP_DRIFT) && b.axis != AX_NONE && !slot_live[slot])
            b.op = OP_INIT;
        b.acc = random_word();
        b.vel = random_word();
        b.pos = random_word();
        b.ctr = random_word();
        b.wb  = 1'($urandom_range(1));
        return b;
    endfunction

    task automatic issue_beat(input t_beat_in b, input bit typed, input t_beat_out want);
        t_beat_out predicted;
        start      <= 1'b1;
        drive_beat <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = integrate_beat(b);
        expected_results.push_back(typed ? want : predicted);
        if (!calm_stretch && $urandom_range(99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) issue_beat(random_beat(), 1'b0, '0);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] readback;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == REG_TIME_STEP) step_q016 = value[DT_W-1:0];
        else centre_mode = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (addr == REG_TIME_STEP && readback[DT_W-1:0] !== value[DT_W-1:0]) begin
            $error("time_step readback: expected %0d, got %0d", value[DT_W-1:0],
                   readback[DT_W-1:0]);
            fail_count++;
        end
        if (addr == REG_SOLVENT_MODE && readback[0] !== value[0]) begin
            $error("solvent_center_on readback: expected %0d, got %0d", value[0], readback[0]);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_velocity_out !== oldest_result.vel) begin
                    $error("velocity_out: expected %0d, got %0d", oldest_result.vel,
                           o_velocity_out);
                    fail_count++;
                end
                if (o_velocity_update !== oldest_result.upd) begin
                    $error("velocity_update: expected %0d, got %0d", oldest_result.upd,
                           o_velocity_update);
                    fail_count++;
                end
                if (o_position_out !== oldest_result.pos) begin
                    $error("position_out: expected %0d, got %0d", oldest_result.pos,
                           o_position_out);
                    fail_count++;
                end
                if (o_solvent_center_out !== oldest_result.ctr) begin
                    $error("solvent_center_out: expected %0d, got %0d", oldest_result.ctr,
                           o_solvent_center_out);
                    fail_count++;
                end
                if (o_saturated !== oldest_result.sat) begin
                    $error("saturated: expected %0d, got %0d", oldest_result.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        // pass-through rows and row 1 carry their result; the rest go through the predictor
        directed_rows[0]  = '{'{OP_NONE, 10'd1023, AX_Z, MAXW, MINW, MAXW, MINW, 1'b1}, 1'b1,
                              '{MINW, 1'b0, MAXW, MINW, 1'b0}};
        directed_rows[1]  = '{'{OP_INIT, 10'd0, AX_X, 32'sd0, MAXW, MINW, MAXW, 1'b0}, 1'b1,
                              '{MAXW, 1'b0, MINW, MAXW, 1'b0}};
        directed_rows[2]  = '{'{OP_INIT, 10'd0, AX_Y, MAXW, MAXW, 32'sd0, 32'sd0, 1'b0},
                              1'b0, '0};
        directed_rows[3]  = '{'{OP_INIT, 10'd0, AX_Z, MAXW, MINW, 32'sd1, -32'sd1, 1'b1},
                              1'b0, '0};
        directed_rows[4]  = '{'{OP_INIT, 10'd1023, AX_X, 32'sd12345, -32'sd5000, 32'sd7,
                                32'sd9, 1'b0}, 1'b0, '0};
        directed_rows[5]  = '{'{OP_INIT, 10'd1023, AX_Y, MINW, MAXW, MINW, MINW, 1'b1},
                              1'b0, '0};
        directed_rows[6]  = '{'{OP_INIT, 10'd512, AX_NONE, MAXW, 32'sh5555_aaaa,
                                32'sh2aaa_5555, -32'sd3, 1'b1}, 1'b1,
                              '{32'sh5555_aaaa, 1'b0, 32'sh2aaa_5555, -32'sd3, 1'b0}};
        directed_rows[7]  = '{'{OP_KICK, 10'd0, AX_X, MAXW, 32'sd0, 32'sd0, 32'sd0, 1'b1},
                              1'b0, '0};
        directed_rows[8]  = '{'{OP_KICK, 10'd0, AX_Y, MINW, MAXW, MAXW, MAXW, 1'b0},
                              1'b0, '0};
        directed_rows[9]  = '{'{OP_KICK, 10'd1023, AX_X, -32'sd77777, 32'sd0, 32'sd0,
                                32'sd0, 1'b1}, 1'b0, '0};
        directed_rows[10] = '{'{OP_DRIFT, 10'd0, AX_X, 32'sd0, 32'sd0, MAXW, MAXW, 1'b0},
                              1'b0, '0};
        directed_rows[11] = '{'{OP_DRIFT, 10'd0, AX_Y, MAXW, MINW, MINW, MINW, 1'b1},
                              1'b0, '0};
        directed_rows[12] = '{'{OP_DRIFT, 10'd0, AX_Z, 32'sd0, 32'sd0, 32'sd100, -32'sd100,
                                1'b0}, 1'b0, '0};
        directed_rows[13] = '{'{OP_DRIFT, 10'd1023, AX_Y, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                                1'b0}, 1'b0, '0};
        directed_rows[14] = '{'{OP_DRIFT, 10'd0, AX_X, 32'sd0, 32'sd0, MINW, MAXW, 1'b0},
                              1'b0, '0};
        directed_rows[15] = '{'{OP_KICK, 10'd0, AX_X, -32'sd65536, 32'sd0, 32'sd0, 32'sd0,
                                1'b1}, 1'b0, '0};
        directed_rows[16] = '{'{OP_NONE, 10'd0, AX_X, MINW, 32'sd42, -32'sd42, MAXW, 1'b1},
                              1'b1, '{32'sd42, 1'b0, -32'sd42, MAXW, 1'b0}};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++)
            issue_beat(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);
        run_random(100);

        set_register(REG_TIME_STEP, 32'd65535);
        set_register(REG_SOLVENT_MODE, 32'd1);
        calm_stretch = 1'b1;
        run_random(110);
        calm_stretch = 1'b0;

        set_register(REG_TIME_STEP, 32'd1);
        set_register(REG_SOLVENT_MODE, 32'd0);
        run_random(40);
        settle();
        run_random(40);

        // zero step: every product vanishes
        set_register(REG_TIME_STEP, 32'd0);
        set_register(REG_SOLVENT_MODE, 32'd1);
        run_random(40);

        set_register(REG_TIME_STEP, 32'($urandom_range(2, 65534)));
        set_register(REG_SOLVENT_MODE, 32'd0);
        run_random(60);

        set_register(REG_TIME_STEP, 32'd32768);
        set_register(REG_SOLVENT_MODE, 32'd1);
        run_random(60);

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
